/* rtl/multi_voice_pcm_mixer_macros.svh */
// Assertion macros for the multi-voice PCM mixer.
// Uses the clk and arst_n names of the module that includes it.
`ifndef MULTI_VOICE_PCM_MIXER_MACROS_SVH
`define MULTI_VOICE_PCM_MIXER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MVPM_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define MVPM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mvpm_pkg.sv */
// Shared types and constants for the multi-voice PCM mixer.
// No dependencies; imported by mvpm_mac and the top-level mixer.
package mvpm_pkg;

	localparam int DEF_VOICES     = 8;
	localparam int DEF_MAX_CLIP   = 4096;
	localparam int DEF_MAX_RENDER = 64;

	localparam logic [7:0] SILENCE    = 8'd128;
	localparam logic [7:0] FULL_SCALE = 8'd255;
	localparam int         MASK_W     = 8;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_START  = 2'd1,
		OP_STOP   = 2'd2,
		OP_RENDER = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT,
		ST_RESP
	} state_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [2:0]  voice;
		logic [11:0] sample_addr;
		logic [7:0]  sample_byte;
		logic [12:0] clip_length;
		logic [7:0]  gain;
		logic [6:0]  render_count;
	} cmd_t;

	typedef struct packed {
		logic [7:0]        out_sample;
		logic              is_sample;
		logic              last;
		logic              start_ok;
		logic [MASK_W-1:0] active_mask;
	} res_t;

	// Control from the sequencer to the shared multiply-accumulate unit
	typedef struct packed {
		logic       clear;
		logic       acc_en;
		logic [7:0] gain;
	} mac_ctrl_t;

endpackage

/* rtl/mvpm_store.sv */
// Sample store of the mixer: one byte-wide memory holding every voice's clip.
// One write port, one read port with registered read data.
module mvpm_store #(
	parameter int VOICES = 8,
	parameter int AW     = 12,
	parameter int VW     = 3
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [VW+AW-1:0]   wr_addr,
	input  logic [7:0]         wr_data,
	input  logic               rd_en,
	input  logic [VW+AW-1:0]   rd_addr,
	output logic [7:0]         rd_data
);

	localparam int DEPTH = VOICES << AW;

	logic [7:0] mem [0:DEPTH-1];
	logic [7:0] rd_data_q;

	// write a request's byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read the byte of the voice under scan
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/mvpm_mac.sv */
// Shared multiply-accumulate unit: scales one voice byte by its gain,
// divides by full scale toward zero and adds into the mix. Uses mvpm_pkg.
module mvpm_mac #(
	parameter int VOICES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mvpm_pkg::mac_ctrl_t ctrl,
	input  logic [7:0]          sample_byte,
	output logic [7:0]          mix_sample
);
	import mvpm_pkg::*;

	localparam int ACC_W = $clog2((VOICES + 2) * 128) + 1;

	logic signed [ACC_W-1:0] acc_q;
	logic [8:0]              delta_u;
	logic                    neg;
	logic [8:0]              dabs;
	logic [15:0]             prod;
	logic [15:0]             quo_sum;
	logic [7:0]              quo;
	logic signed [ACC_W-1:0] contrib;

	// magnitude of the byte about silence, times gain, divided by 255
	always_comb begin
		delta_u = {1'b0, sample_byte} - {1'b0, SILENCE};
		neg     = delta_u[8];
		dabs    = neg ? (9'd0 - delta_u) : delta_u;
		prod    = dabs[7:0] * ctrl.gain;
		// exact x / 255 for x below 65535
		quo_sum = prod + 16'd1 + (prod >> 8);
		quo     = quo_sum[15:8];
		contrib = neg ? -$signed(ACC_W'(quo)) : $signed(ACC_W'(quo));
	end

	// hold the running mix, starting from silence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= ACC_W'(SILENCE);
		end else if (ctrl.clear) begin
			acc_q <= ACC_W'(SILENCE);
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + contrib;
		end
	end

	// clamp the mix to the byte range
	always_comb begin
		if (acc_q < 0) begin
			mix_sample = 8'd0;
		end else if (acc_q > $signed(ACC_W'(FULL_SCALE))) begin
			mix_sample = FULL_SCALE;
		end else begin
			mix_sample = acc_q[7:0];
		end
	end

endmodule

/* rtl/multi_voice_pcm_mixer.sv */
// Multi-voice PCM mixer: up to VOICES one-shot voices of unsigned 8-bit
// PCM mixed into one unsigned 8-bit stream. A request writes a sample byte,
// starts or stops a voice, or renders up to MAX_RENDER samples. Write, start
// and stop give one result each. For each rendered sample the sequencer
// walks the voices one per cycle through the single read port of the sample
// store and the shared multiply-accumulate unit, then drains that unit in
// the drain state and presents the sample in the emit state, which it holds
// while a full result register is stalled by the receiver. The block takes
// no new request while one is at work. The sample store needs no clearing
// after reset; bytes that were never written read as anything. Depends on
// mvpm_pkg, mvpm_store and mvpm_mac.
`include "multi_voice_pcm_mixer_macros.svh"

module multi_voice_pcm_mixer #(
	parameter int VOICES     = mvpm_pkg::DEF_VOICES,
	parameter int MAX_CLIP   = mvpm_pkg::DEF_MAX_CLIP,
	parameter int MAX_RENDER = mvpm_pkg::DEF_MAX_RENDER
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  mvpm_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output mvpm_pkg::res_t res
);
	import mvpm_pkg::*;

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int AW = $clog2(MAX_CLIP);
	localparam int OW = $clog2(MAX_CLIP + 1);
	localparam int RW = $clog2(MAX_RENDER + 1);

	state_t state_q, state_d;

	logic [OW-1:0] off_q  [VOICES];
	logic [OW-1:0] len_q  [VOICES];
	logic [7:0]    gain_q [VOICES];
	logic [VOICES-1:0] on_q;

	logic [VW-1:0] vi_q;
	logic [RW-1:0] left_q;
	logic          ok_q;
	logic          valid_s1;
	logic [7:0]    gain_s1;

	logic          res_valid_q;
	res_t          res_q;

	logic [VW-1:0] cmd_vi;
	logic          voice_ok, addr_ok, len_ok;
	logic [6:0]    cnt_clamp;
	logic          vi_last, res_free;
	logic [OW-1:0] off_next;

	logic          st_we, do_start, do_stop, take;
	logic          issue, load_sample, load_plain, mac_clear;
	logic [7:0]    rd_byte, mix_sample;
	logic [MASK_W-1:0] mask;
	mac_ctrl_t     mac_ctrl;

	// decode the request fields
	always_comb begin
		cmd_vi    = VW'(cmd.voice);
		voice_ok  = 32'(cmd.voice) < VOICES;
		addr_ok   = 32'(cmd.sample_addr) < MAX_CLIP;
		len_ok    = (cmd.clip_length != 13'd0) && (32'(cmd.clip_length) <= MAX_CLIP);
		cnt_clamp = (32'(cmd.render_count) > MAX_RENDER) ? 7'(MAX_RENDER) : cmd.render_count;
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign take      = cmd_valid && !cmd_stall;
	assign vi_last   = (vi_q == VW'(VOICES - 1));
	assign res_free  = !res_valid_q || !res_stall;
	assign off_next  = off_q[vi_q] + OW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.opcode == OP_RENDER && cnt_clamp != 7'd0) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SCAN: begin
				if (vi_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (res_free) begin
					state_d = (left_q == RW'(1)) ? ST_IDLE : ST_SCAN;
				end
			end
			ST_RESP: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		st_we       = 1'b0;
		do_start    = 1'b0;
		do_stop     = 1'b0;
		issue       = 1'b0;
		load_sample = 1'b0;
		load_plain  = 1'b0;
		mac_clear   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				mac_clear = 1'b1;
				if (cmd_valid) begin
					st_we     = (cmd.opcode == OP_WRITE) && voice_ok && addr_ok;
					do_start  = (cmd.opcode == OP_START) && voice_ok && len_ok;
					do_stop   = (cmd.opcode == OP_STOP) && voice_ok;
				end
			end
			ST_SCAN:  issue = 1'b1;
			ST_DRAIN: ;
			ST_EMIT: begin
				load_sample = res_free;
				mac_clear   = res_free;
			end
			ST_RESP:  load_plain = res_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// advance the voice counter, the samples left and the start flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vi_q   <= '0;
			left_q <= '0;
			ok_q   <= 1'b0;
		end else begin
			if (take) begin
				ok_q   <= do_start;
				left_q <= RW'(cnt_clamp);
			end
			if (issue) begin
				vi_q <= vi_last ? '0 : vi_q + VW'(1);
			end
			if (load_sample) begin
				left_q <= left_q - RW'(1);
			end
		end
	end

	// voice on flags: set by start, drop on stop or at the clip end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q <= '0;
		end else begin
			for (int i = 0; i < VOICES; i++) begin
				if (do_start && cmd_vi == VW'(i)) begin
					on_q[i] <= 1'b1;
				end else if (do_stop && cmd_vi == VW'(i)) begin
					on_q[i] <= 1'b0;
				end else if (issue && vi_q == VW'(i) && on_q[i]) begin
					on_q[i] <= (off_next < len_q[i]);
				end
			end
		end
	end

	// voice length, gain and play offset
	always_ff @(posedge clk) begin
		for (int i = 0; i < VOICES; i++) begin
			if (do_start && cmd_vi == VW'(i)) begin
				len_q[i]  <= OW'(cmd.clip_length);
				gain_q[i] <= cmd.gain;
				off_q[i]  <= '0;
			end else if (issue && vi_q == VW'(i) && on_q[i]) begin
				off_q[i] <= off_next;
			end
		end
	end

	// carry the scanned voice's gain alongside its memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue && on_q[vi_q];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			gain_s1 <= gain_q[vi_q];
		end
	end

	mvpm_store #(
		.VOICES (VOICES),
		.AW     (AW),
		.VW     (VW)
	) u_store (
		.clk     (clk),
		.wr_en   (st_we),
		.wr_addr ({cmd_vi, AW'(cmd.sample_addr)}),
		.wr_data (cmd.sample_byte),
		.rd_en   (issue),
		.rd_addr ({vi_q, off_q[vi_q][AW-1:0]}),
		.rd_data (rd_byte)
	);

	always_comb begin
		mac_ctrl.clear  = mac_clear;
		mac_ctrl.acc_en = valid_s1;
		mac_ctrl.gain   = gain_s1;
	end

	mvpm_mac #(
		.VOICES (VOICES)
	) u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (mac_ctrl),
		.sample_byte (rd_byte),
		.mix_sample  (mix_sample)
	);

	// active mask shows the first eight voices only
	always_comb begin
		mask = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (i < VOICES) begin
				mask[i] = on_q[i];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_sample || load_plain) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_sample) begin
			res_q.out_sample  <= mix_sample;
			res_q.is_sample   <= 1'b1;
			res_q.last        <= (left_q == RW'(1));
			res_q.start_ok    <= 1'b0;
			res_q.active_mask <= mask;
		end else if (load_plain) begin
			res_q.out_sample  <= SILENCE;
			res_q.is_sample   <= 1'b0;
			res_q.last        <= 1'b1;
			res_q.start_ok    <= ok_q;
			res_q.active_mask <= mask;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`MVPM_ASSERT_IMPL(a_plain_is_silent, res_valid && !res.is_sample, res.out_sample == SILENCE && res.last, "result without a sample is not silent and last")
	`MVPM_ASSERT_IMPL(a_ok_only_plain, res_valid && res.start_ok, !res.is_sample, "start flag set on a rendered sample")
	`MVPM_ASSERT_IMPL(a_scan_in_range, state_q == ST_SCAN, 32'(vi_q) < VOICES && left_q != '0, "voice scan out of range")
	`MVPM_ASSERT_NEXT(a_busy_mid_render, state_q == ST_EMIT && res_free && left_q != RW'(1), state_q == ST_SCAN && cmd_stall, "request taken before a render finished")

endmodule
